// File: hdl/srcl_pkg.sv
package srcl_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int FIFO_DEPTH_DEF = 2;

  localparam int CLIP_W = 15;
  localparam logic [CLIP_W-1:0] CLIP_MAX = 15'h7fff;

  // Configuration register indexes.
  localparam logic [1:0] CFG_ORIGIN_X = 2'd0;
  localparam logic [1:0] CFG_ORIGIN_Y = 2'd1;
  localparam logic [1:0] CFG_WIDTH    = 2'd2;
  localparam logic [1:0] CFG_HEIGHT   = 2'd3;

  typedef struct packed {
    logic [15:0]       origin_x;
    logic [15:0]       origin_y;
    logic [CLIP_W-1:0] width;
    logic [CLIP_W-1:0] height;
  } cfg_t;

  // One classified axis word, passed from the front end to the back end.
  typedef struct packed {
    logic              axis;
    logic              ok;
    logic              bypass;
    logic [15:0]       scr;
    logic [CLIP_W-1:0] dx;
    logic [CLIP_W-1:0] dw;
    logic [CLIP_W-1:0] bsize;
    logic [CLIP_W-1:0] gsize;
  } entry_t;

  typedef struct packed {
    logic              visible;
    logic [15:0]       screen_x;
    logic [15:0]       screen_y;
    logic [CLIP_W-1:0] dst_x;
    logic [CLIP_W-1:0] dst_y;
    logic [CLIP_W-1:0] dst_w;
    logic [CLIP_W-1:0] dst_h;
    logic [CLIP_W-1:0] src_x;
    logic [CLIP_W-1:0] src_y;
    logic [CLIP_W-1:0] src_w;
    logic [CLIP_W-1:0] src_h;
  } result_t;

endpackage

// File: hdl/srcl_front.sv
module srcl_front #(
  parameter int COORD_BITS = srcl_pkg::COORD_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_axis,
  input  logic                in_sprite_active,
  input  logic signed [15:0]  in_dest_pos,
  input  logic signed [15:0]  in_box_pos,
  input  logic [14:0]         in_box_size,
  input  logic signed [15:0]  in_anchor_offset,
  input  logic [14:0]         in_clip_pos,
  input  logic [14:0]         in_clip_size,
  input  logic [14:0]         in_graphic_size,
  input  srcl_pkg::cfg_t      cfg,
  output logic                push_valid,
  input  logic                push_ready,
  output srcl_pkg::entry_t    push_data
);
  import srcl_pkg::*;

  localparam int SUM_W = 19;
  localparam int EXT_W = ((COORD_BITS > SUM_W) ? COORD_BITS : SUM_W) + 1;

  logic                s1_valid_r;
  logic                s1_valid_nxt;
  logic                s1_axis_r;
  logic                s1_active_r;
  logic signed [17:0]  s1_start_r;
  logic signed [18:0]  s1_end_r;
  logic [14:0]         s1_bsize_r;
  logic [14:0]         s1_cpos_r;
  logic [14:0]         s1_csize_r;
  logic [14:0]         s1_gsize_r;

  logic signed [17:0]  start_in;
  logic signed [18:0]  end_in;
  logic                accept;

  logic [14:0]         win;
  logic signed [15:0]  origin;
  logic                win_zero;
  logic                reject;
  logic                neg;
  logic signed [17:0]  start_c;
  logic signed [18:0]  dpos;
  logic [14:0]         dx_clip;
  logic signed [18:0]  end_c;
  logic signed [18:0]  width_c;
  logic signed [17:0]  scr_base;
  logic signed [SUM_W-1:0] scr_sum;
  logic signed [EXT_W-1:0] sum_ext;
  logic signed [EXT_W-1:0] coord_hi;
  logic signed [EXT_W-1:0] coord_lo;
  logic signed [EXT_W-1:0] scr_sat;

  assign start_in = 18'(in_dest_pos) - 18'(in_box_pos) - 18'(in_anchor_offset);
  assign end_in   = 19'(start_in) + $signed({4'b0000, in_box_size});

  assign in_ready   = !s1_valid_r || push_ready;
  assign accept     = in_valid && in_ready;
  assign push_valid = s1_valid_r;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (push_ready) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_axis_r   <= in_axis;
      s1_active_r <= in_sprite_active;
      s1_start_r  <= start_in;
      s1_end_r    <= end_in;
      s1_bsize_r  <= in_box_size;
      s1_cpos_r   <= in_clip_pos;
      s1_csize_r  <= in_clip_size;
      s1_gsize_r  <= in_graphic_size;
    end
  end

  // Clip against the window of the word's axis.
  assign win      = s1_axis_r ? cfg.height : cfg.width;
  assign origin   = s1_axis_r ? $signed(cfg.origin_y) : $signed(cfg.origin_x);
  assign win_zero = (win == '0);
  assign reject   = (s1_start_r > $signed({3'b000, win})) || (s1_end_r < 19'sd0);
  assign neg      = s1_start_r < 18'sd0;
  assign start_c  = neg ? 18'sd0 : s1_start_r;

  // A start left of the window moves into the destination clip position.
  assign dpos    = $signed({4'b0000, s1_cpos_r}) - 19'(s1_start_r);
  assign dx_clip = !neg ? s1_cpos_r :
                   ((dpos > 19'sd32767) ? CLIP_MAX : dpos[14:0]);

  assign end_c   = (s1_end_r > $signed({4'b0000, win})) ? $signed({4'b0000, win}) : s1_end_r;
  assign width_c = end_c - 19'(start_c);

  assign scr_base = win_zero ? s1_start_r : start_c;
  assign scr_sum  = SUM_W'(scr_base) + SUM_W'(origin);
  assign sum_ext  = EXT_W'(scr_sum);
  assign coord_hi = $signed({{(EXT_W-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}});
  assign coord_lo = ~coord_hi;
  assign scr_sat  = (sum_ext > coord_hi) ? coord_hi :
                    ((sum_ext < coord_lo) ? coord_lo : sum_ext);

  always_comb begin
    push_data        = '0;
    push_data.axis   = s1_axis_r;
    push_data.ok     = (win_zero || !reject) && s1_active_r;
    push_data.bypass = win_zero;
    push_data.scr    = scr_sat[15:0];
    push_data.dx     = win_zero ? s1_cpos_r : dx_clip;
    push_data.dw     = win_zero ? s1_csize_r : width_c[14:0];
    push_data.bsize  = s1_bsize_r;
    push_data.gsize  = s1_gsize_r;
  end

endmodule

// File: hdl/srcl_fifo.sv
module srcl_fifo #(
  parameter int DEPTH = srcl_pkg::FIFO_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  srcl_pkg::entry_t wr_data,
  output logic             rd_valid,
  input  logic             rd_ready,
  output srcl_pkg::entry_t rd_data
);
  import srcl_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  entry_t          mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r;
  logic [PW-1:0]   rd_ptr_r;
  logic [CW-1:0]   count_r;
  logic            push;
  logic            pop;

  assign wr_ready = (count_r != CW'(DEPTH));
  assign rd_valid = (count_r != '0);
  assign rd_data  = mem_r[rd_ptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10: count_r <= count_r + 1'b1;
        2'b01: count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// File: hdl/srcl_scale.sv
module srcl_scale (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [14:0] gsize,
  input  logic [14:0] val,
  input  logic [14:0] bsize,
  output logic        busy,
  output logic [14:0] quo
);
  import srcl_pkg::*;

  typedef enum logic [3:0] {
    SC_IDLE = 4'b0001,
    SC_MUL  = 4'b0010,
    SC_CHK  = 4'b0100,
    SC_DIV  = 4'b1000
  } scale_state_t;

  scale_state_t state_r, state_nxt;
  logic [14:0]  gsize_r;
  logic [14:0]  val_r;
  logic [14:0]  bsize_r;
  logic [29:0]  prod_r, prod_nxt;
  logic [14:0]  rem_r, rem_nxt;
  logic [14:0]  quo_r, quo_nxt;
  logic [3:0]   cnt_r, cnt_nxt;

  logic [15:0]  trial;
  logic [15:0]  diff;
  logic         fits;

  assign trial = {rem_r, prod_r[14]};
  assign diff  = trial - {1'b0, bsize_r};
  assign fits  = trial >= {1'b0, bsize_r};
  assign busy  = (state_r != SC_IDLE);
  assign quo   = quo_r;

  always_comb begin
    state_nxt = state_r;
    prod_nxt  = prod_r;
    rem_nxt   = rem_r;
    quo_nxt   = quo_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      SC_IDLE: begin
        if (start) begin
          state_nxt = SC_MUL;
        end
      end
      SC_MUL: begin
        prod_nxt  = 30'(gsize_r) * 30'(val_r);
        state_nxt = SC_CHK;
      end
      SC_CHK: begin
        // A quotient of 2^15 or more saturates without dividing.
        if (prod_r[29:15] >= bsize_r) begin
          quo_nxt   = CLIP_MAX;
          state_nxt = SC_IDLE;
        end else begin
          rem_nxt   = prod_r[29:15];
          quo_nxt   = '0;
          cnt_nxt   = 4'(CLIP_W - 1);
          state_nxt = SC_DIV;
        end
      end
      SC_DIV: begin
        rem_nxt  = fits ? diff[14:0] : trial[14:0];
        quo_nxt  = {quo_r[13:0], fits};
        prod_nxt = {prod_r[28:0], 1'b0};
        cnt_nxt  = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = SC_IDLE;
        end
      end
      default: begin
        state_nxt = SC_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SC_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == SC_IDLE && start) begin
      gsize_r <= gsize;
      val_r   <= val;
      bsize_r <= bsize;
    end
    prod_r <= prod_nxt;
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    cnt_r  <= cnt_nxt;
  end

endmodule

// File: hdl/srcl_back.sv
module srcl_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              ent_valid,
  output logic              ent_ready,
  input  srcl_pkg::entry_t  ent,
  output logic              out_valid,
  input  logic              out_ready,
  output srcl_pkg::result_t res
);
  import srcl_pkg::*;

  typedef enum logic [2:0] {
    B_IDLE = 3'b001,
    B_WAIT = 3'b010,
    B_FIN  = 3'b100
  } back_state_t;

  back_state_t state_r, state_nxt;
  entry_t      cur_r;
  logic        held_ok_r;
  logic [15:0] held_scr_r;
  logic [14:0] held_dx_r;
  logic [14:0] held_dw_r;
  logic [14:0] held_sx_r;
  logic [14:0] held_sw_r;
  logic        out_valid_r, out_valid_nxt;
  result_t     res_r, res_nxt;

  logic        need_div_in;
  logic        need_div_cur;
  logic        start;
  logic        busy_x, busy_w;
  logic [14:0] quo_x, quo_w;
  logic [14:0] sx, sw;
  logic        out_free;
  logic        fin_x;
  logic        fin_y;

  assign need_div_in  = ent.ok && !ent.bypass && (ent.bsize != '0);
  assign need_div_cur = cur_r.ok && !cur_r.bypass && (cur_r.bsize != '0);
  assign ent_ready    = (state_r == B_IDLE);
  assign start        = (state_r == B_IDLE) && ent_valid && need_div_in;

  srcl_scale u_scale_pos (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .gsize (ent.gsize),
    .val   (ent.dx),
    .bsize (ent.bsize),
    .busy  (busy_x),
    .quo   (quo_x)
  );

  srcl_scale u_scale_ext (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .gsize (ent.gsize),
    .val   (ent.dw),
    .bsize (ent.bsize),
    .busy  (busy_w),
    .quo   (quo_w)
  );

  // A pass-through axis keeps its clip as the source clip.
  assign sx = need_div_cur ? quo_x : ((cur_r.ok && cur_r.bypass) ? cur_r.dx : '0);
  assign sw = need_div_cur ? quo_w : ((cur_r.ok && cur_r.bypass) ? cur_r.dw : '0);

  assign out_free = !out_valid_r || out_ready;
  assign fin_x    = (state_r == B_FIN) && !cur_r.axis;
  assign fin_y    = (state_r == B_FIN) && cur_r.axis && out_free;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_IDLE: begin
        if (ent_valid) begin
          state_nxt = need_div_in ? B_WAIT : B_FIN;
        end
      end
      B_WAIT: begin
        if (!busy_x && !busy_w) begin
          state_nxt = B_FIN;
        end
      end
      B_FIN: begin
        if (fin_x || fin_y) begin
          state_nxt = B_IDLE;
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  always_comb begin
    res_nxt = '0;
    if (cur_r.ok && held_ok_r) begin
      res_nxt.visible  = 1'b1;
      res_nxt.screen_x = held_scr_r;
      res_nxt.screen_y = cur_r.scr;
      res_nxt.dst_x    = held_dx_r;
      res_nxt.dst_y    = cur_r.dx;
      res_nxt.dst_w    = held_dw_r;
      res_nxt.dst_h    = cur_r.dw;
      res_nxt.src_x    = held_sx_r;
      res_nxt.src_y    = sx;
      res_nxt.src_w    = held_sw_r;
      res_nxt.src_h    = sw;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (fin_y) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      held_ok_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (fin_x) begin
        held_ok_r <= cur_r.ok;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == B_IDLE && ent_valid) begin
      cur_r <= ent;
    end
    if (fin_x) begin
      held_scr_r <= cur_r.scr;
      held_dx_r  <= cur_r.dx;
      held_dw_r  <= cur_r.dw;
      held_sx_r  <= sx;
      held_sw_r  <= sw;
    end
    if (fin_y) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign res       = res_r;

endmodule

// File: hdl/sprite_rect_clipper_unit.sv
// Output: a vertical word raises out_valid once its result is done, sooner when both quotients
// saturate or when no scaling is needed.
// Flow: the back end takes a new word only after it has finished the last one; it scales with two
// 15-step dividers side by side, and a waiting result word stalls it further.
// Reset: synchronous, active low; clears the window registers to zero, the queue, the ok flag
// of the held horizontal result and the output valid register.
module sprite_rect_clipper_unit #(
  parameter int COORD_BITS = srcl_pkg::COORD_BITS_DEF,
  parameter int FIFO_DEPTH = srcl_pkg::FIFO_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,

  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,

  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_axis,
  input  logic               in_sprite_active,
  input  logic signed [15:0] in_dest_pos,
  input  logic signed [15:0] in_box_pos,
  input  logic [14:0]        in_box_size,
  input  logic signed [15:0] in_anchor_offset,
  input  logic [14:0]        in_clip_pos,
  input  logic [14:0]        in_clip_size,
  input  logic [14:0]        in_graphic_size,

  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_visible,
  output logic signed [15:0] out_screen_x,
  output logic signed [15:0] out_screen_y,
  output logic [14:0]        out_dst_clip_x,
  output logic [14:0]        out_dst_clip_y,
  output logic [14:0]        out_dst_clip_w,
  output logic [14:0]        out_dst_clip_h,
  output logic [14:0]        out_src_clip_x,
  output logic [14:0]        out_src_clip_y,
  output logic [14:0]        out_src_clip_w,
  output logic [14:0]        out_src_clip_h
);
  import srcl_pkg::*;

  cfg_t    cfg_r;
  entry_t  push_data;
  entry_t  pop_data;
  logic    push_valid;
  logic    push_ready;
  logic    pop_valid;
  logic    pop_ready;
  result_t res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ORIGIN_X: cfg_r.origin_x <= cfg_data;
        CFG_ORIGIN_Y: cfg_r.origin_y <= cfg_data;
        CFG_WIDTH:    cfg_r.width    <= cfg_data[14:0];
        CFG_HEIGHT:   cfg_r.height   <= cfg_data[14:0];
        default:      cfg_r          <= cfg_r;
      endcase
    end
  end

  srcl_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_axis          (in_axis),
    .in_sprite_active (in_sprite_active),
    .in_dest_pos      (in_dest_pos),
    .in_box_pos       (in_box_pos),
    .in_box_size      (in_box_size),
    .in_anchor_offset (in_anchor_offset),
    .in_clip_pos      (in_clip_pos),
    .in_clip_size     (in_clip_size),
    .in_graphic_size  (in_graphic_size),
    .cfg              (cfg_r),
    .push_valid       (push_valid),
    .push_ready       (push_ready),
    .push_data        (push_data)
  );

  srcl_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (push_valid),
    .wr_ready (push_ready),
    .wr_data  (push_data),
    .rd_valid (pop_valid),
    .rd_ready (pop_ready),
    .rd_data  (pop_data)
  );

  srcl_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .ent_valid (pop_valid),
    .ent_ready (pop_ready),
    .ent       (pop_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res       (res)
  );

  assign out_visible    = res.visible;
  assign out_screen_x   = res.screen_x;
  assign out_screen_y   = res.screen_y;
  assign out_dst_clip_x = res.dst_x;
  assign out_dst_clip_y = res.dst_y;
  assign out_dst_clip_w = res.dst_w;
  assign out_dst_clip_h = res.dst_h;
  assign out_src_clip_x = res.src_x;
  assign out_src_clip_y = res.src_y;
  assign out_src_clip_w = res.src_w;
  assign out_src_clip_h = res.src_h;

endmodule
